FILE: rtl/stripe_segment_splitter_core_macros.svh
// ----------------------------------------------------------------------------
// Stripe segment splitter assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef STRIPE_SEGMENT_SPLITTER_CORE_MACROS_SVH
`define STRIPE_SEGMENT_SPLITTER_CORE_MACROS_SVH

// Checked on every clock edge outside of reset.
`define SSPLT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define SSPLT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/ssplt_pkg.sv
// ----------------------------------------------------------------------------
// Stripe segment splitter package
// Widths, register codes, word types and clamp helpers shared by the block.
// ----------------------------------------------------------------------------
package ssplt_pkg;

   localparam int OFF_W      = 48;  // file and server offsets
   localparam int REQ_LEN_W  = 32;  // requested byte count
   localparam int BUF_W      = 16;  // buffer length and positions inside it
   localparam int UNIT_W     = 21;  // stripe unit and request size limit
   localparam int UPOS_W     = 20;  // position inside one stripe unit
   localparam int COUNT_W    = 5;   // stripe count
   localparam int SRV_OUT_W  = 4;   // server index on the result word
   localparam int LEN_W      = 25;  // capped request length, below 2^25
   localparam int W_W        = 26;  // stripe width, unit times count
   localparam int DCNT_W     = 6;   // divide step counter

   // Largest stripe count honored; must stay below 2^COUNT_W.
   localparam int MAX_SERVERS = 16;

   // Most segment words one buffer may produce, and the counter for them.
   localparam int MAX_SEGS  = 17;
   localparam int SEG_CNT_W = 5;

   localparam logic [UNIT_W-1:0]  UNIT_MIN    = UNIT_W'(4096);
   localparam logic [UNIT_W-1:0]  UNIT_MAX    = UNIT_W'(1048576);
   localparam logic [UNIT_W-1:0]  UNIT_RESET  = UNIT_W'(65536);
   localparam logic [UNIT_W-1:0]  MRS_RESET   = UNIT_W'(1048576);
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SIZE        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVER_COUNT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REQUEST_SIZE = 2'd2;

   localparam int CMD_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic                 new_request;
      logic [OFF_W-1:0]     file_offset;
      logic [REQ_LEN_W-1:0] request_length;
      logic [BUF_W-1:0]     buffer_length;
   } req_type;

   typedef struct packed {
      logic [SRV_OUT_W-1:0] server_index;
      logic [OFF_W-1:0]     server_offset;
      logic [BUF_W-1:0]     seg_count;
      logic [BUF_W-1:0]     buffer_offset;
      logic                 last;
      logic                 request_done;
   } rsp_type;

   // Classified word handed from the front to the back.
   typedef struct packed {
      logic             new_request;
      logic [OFF_W-1:0] file_offset;
      logic [LEN_W-1:0] length;
      logic [BUF_W-1:0] buffer_length;
   } cmd_type;

   // Effective stripe geometry and a pulse on any register write.
   typedef struct packed {
      logic [UNIT_W-1:0]  unit;
      logic [COUNT_W-1:0] count;
      logic               changed;
   } cfg_type;

   function automatic logic [UNIT_W-1:0] clamp_unit(input logic [UNIT_W-1:0] v);
      logic [UNIT_W-1:0] r;
      r = v;
      if (v < UNIT_MIN) begin
         r = UNIT_MIN;
      end else if (v > UNIT_MAX) begin
         r = UNIT_MAX;
      end
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = COUNT_W'(1);
      end else if (v > COUNT_W'(MAX_SERVERS)) begin
         r = COUNT_W'(MAX_SERVERS);
      end
      return r;
   endfunction

endpackage

FILE: rtl/ssplt_fifo.sv
// ----------------------------------------------------------------------------
// Stripe segment splitter queue
// Small first-in first-out register queue used between the block's parts.
// ----------------------------------------------------------------------------
module ssplt_fifo #(
   parameter int DEPTH = ssplt_pkg::RSP_DEPTH_DEFAULT,
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push_ok) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/ssplt_front.sv
// ----------------------------------------------------------------------------
// Stripe segment splitter front end
// Holds the clamped stripe registers and turns request words into commands.
// ----------------------------------------------------------------------------
module ssplt_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ssplt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssplt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_push,
   input  ssplt_pkg::req_type                  req_data,
   input  logic                                cmd_full,
   output logic                                cmd_push,
   output ssplt_pkg::cmd_type                  cmd_data,
   output ssplt_pkg::cfg_type                  cfg
);

   import ssplt_pkg::*;

   logic [UNIT_W-1:0]    unit_ff, unit_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [UNIT_W-1:0]    mrs_ff, mrs_in;
   logic [REQ_LEN_W-1:0] cap;
   logic [REQ_LEN_W-1:0] capped;

   // Registers hold the values already clamped into their legal ranges.
   always_comb begin
      unit_in  = unit_ff;
      count_in = count_ff;
      mrs_in   = mrs_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_UNIT_SIZE:        unit_in  = clamp_unit(UNIT_W'(csr_wdata));
            CSR_SERVER_COUNT:     count_in = clamp_count(COUNT_W'(csr_wdata));
            CSR_MAX_REQUEST_SIZE: mrs_in   = clamp_unit(UNIT_W'(csr_wdata));
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff  <= UNIT_RESET;
         count_ff <= COUNT_RESET;
         mrs_ff   <= MRS_RESET;
      end else begin
         unit_ff  <= unit_in;
         count_ff <= count_in;
         mrs_ff   <= mrs_in;
      end
   end

   // The request is capped at the per-server limit times the stripe count.
   assign cap    = REQ_LEN_W'(mrs_ff) * REQ_LEN_W'(count_ff);
   assign capped = (req_data.request_length < cap) ? req_data.request_length : cap;

   assign cmd_push               = req_push && !cmd_full;
   assign cmd_data.new_request   = req_data.new_request;
   assign cmd_data.file_offset   = req_data.file_offset;
   assign cmd_data.length        = LEN_W'(capped);
   assign cmd_data.buffer_length = req_data.buffer_length;

   assign cfg.unit    = unit_ff;
   assign cfg.count   = count_ff;
   assign cfg.changed = csr_we;

endmodule

FILE: rtl/ssplt_back.sv
// ----------------------------------------------------------------------------
// Stripe segment splitter back end
// Maps the running file offset onto the stripe and cuts buffers into segments.
// ----------------------------------------------------------------------------
module ssplt_back (
   input  logic               clock,
   input  logic               reset,
   input  ssplt_pkg::cfg_type cfg,
   input  logic               cmd_empty,
   input  ssplt_pkg::cmd_type cmd_data,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output ssplt_pkg::rsp_type rsp_wdata
);

   import ssplt_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SUB   = 3'd3;
   localparam logic [2:0] ST_SEG   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic                 valid_ff, valid_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [LEN_W-1:0]     left_ff, left_in;
   logic [BUF_W-1:0]     remain_ff, remain_in;
   logic [BUF_W-1:0]     bufpos_ff, bufpos_in;
   logic [UPOS_W-1:0]    upos_ff, upos_in;
   logic [COUNT_W-1:0]   srv_ff, srv_in;
   logic [OFF_W-1:0]     rbase_ff, rbase_in;
   logic [W_W-1:0]       width_ff, width_in;
   logic [W_W-1:0]       rem_ff, rem_in;
   logic [OFF_W-1:0]     dsh_ff, dsh_in;
   logic [DCNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [SEG_CNT_W-1:0] nseg_ff, nseg_in;

   logic [LEN_W-1:0]   left_after;
   logic               valid_after;
   logic [W_W:0]       div_trial;
   logic               div_ge;
   logic [UNIT_W-1:0]  room;
   logic [LEN_W-1:0]   room_or_left;
   logic [BUF_W-1:0]   cnt;
   logic [LEN_W-1:0]   left_next;
   logic [BUF_W-1:0]   remain_next;
   logic [OFF_W:0]     off_sum;
   logic [UNIT_W-1:0]  upos_sum;
   logic               unit_end;
   logic               seg_last;
   logic               seg_cap;

   // Segment length: the rest of the unit, the request and the buffer.
   assign room         = cfg.unit - UNIT_W'(upos_ff);
   assign room_or_left = (LEN_W'(room) < left_ff) ? LEN_W'(room) : left_ff;
   assign cnt          = (room_or_left < LEN_W'(remain_ff)) ? BUF_W'(room_or_left)
                                                            : remain_ff;
   assign left_next    = left_ff - LEN_W'(cnt);
   assign remain_next  = remain_ff - cnt;
   assign off_sum      = {1'b0, off_ff} + (OFF_W + 1)'(cnt);
   assign upos_sum     = UNIT_W'(upos_ff) + UNIT_W'(cnt);
   assign unit_end     = (upos_sum == cfg.unit);
   assign seg_last     = (remain_next == '0) || (left_next == '0);
   // A buffer stops after its last allowed segment, even with bytes to spare.
   assign seg_cap      = (nseg_ff == SEG_CNT_W'(MAX_SEGS - 1));

   // One restoring divide step of the offset by the stripe width.
   assign div_trial = {rem_ff, dsh_ff[OFF_W-1]};
   assign div_ge    = (div_trial >= (W_W + 1)'(width_ff));

   assign left_after  = cmd_data.new_request ? cmd_data.length : left_ff;
   assign valid_after = cmd_data.new_request ? 1'b0 : valid_ff;

   assign rsp_wdata.server_index  = SRV_OUT_W'(srv_ff);
   assign rsp_wdata.server_offset = rbase_ff + OFF_W'(upos_ff);
   assign rsp_wdata.seg_count     = cnt;
   assign rsp_wdata.buffer_offset = bufpos_ff;
   assign rsp_wdata.last          = seg_last;
   assign rsp_wdata.request_done  = (left_next == '0);

   always_comb begin
      state_in  = state_ff;
      valid_in  = valid_ff;
      off_in    = off_ff;
      left_in   = left_ff;
      remain_in = remain_ff;
      bufpos_in = bufpos_ff;
      upos_in   = upos_ff;
      srv_in    = srv_ff;
      rbase_in  = rbase_ff;
      width_in  = width_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      dcnt_in   = dcnt_ff;
      nseg_in   = nseg_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               remain_in = cmd_data.buffer_length;
               bufpos_in = '0;
               nseg_in   = '0;
               left_in   = left_after;
               valid_in  = valid_after;
               if (cmd_data.new_request) begin
                  off_in = cmd_data.file_offset;
               end
               priority if (cmd_data.buffer_length == '0 || left_after == '0) begin
                  state_in = ST_IDLE;
               end else if (!valid_after) begin
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_SEG;
               end
            end
         end
         ST_SETUP: begin
            width_in = W_W'(W_W'(cfg.unit) * W_W'(cfg.count));
            rem_in   = '0;
            dsh_in   = off_ff;
            dcnt_in  = DCNT_W'(OFF_W - 1);
            rbase_in = '0;
            srv_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // The row base (quotient times unit) is built as quotient bits appear.
            rem_in   = div_ge ? W_W'(div_trial - (W_W + 1)'(width_ff)) : W_W'(div_trial);
            rbase_in = {rbase_ff[OFF_W-2:0], 1'b0} + (div_ge ? OFF_W'(cfg.unit) : '0);
            dsh_in   = {dsh_ff[OFF_W-2:0], 1'b0};
            dcnt_in  = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            // The remainder within the row splits into server and unit position.
            if (rem_ff >= W_W'(cfg.unit)) begin
               rem_in = rem_ff - W_W'(cfg.unit);
               srv_in = srv_ff + 1'b1;
            end else begin
               upos_in  = UPOS_W'(rem_ff);
               valid_in = 1'b1;
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            if (!rsp_full) begin
               rsp_push  = 1'b1;
               left_in   = left_next;
               remain_in = remain_next;
               bufpos_in = bufpos_ff + cnt;
               nseg_in   = nseg_ff + 1'b1;
               off_in    = off_sum[OFF_W-1:0];
               if (unit_end) begin
                  upos_in = '0;
                  if (srv_ff + 1'b1 == cfg.count) begin
                     srv_in   = '0;
                     rbase_in = rbase_ff + OFF_W'(cfg.unit);
                  end else begin
                     srv_in = srv_ff + 1'b1;
                  end
               end else begin
                  upos_in = UPOS_W'(upos_sum);
               end
               // Wrapping past the top of the offset space breaks the
               // running position, so it is mapped again from scratch.
               if (off_sum[OFF_W]) begin
                  valid_in = 1'b0;
               end
               priority if (seg_last || seg_cap) begin
                  state_in = ST_IDLE;
               end else if (off_sum[OFF_W]) begin
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_SEG;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.changed) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         left_ff  <= '0;
         off_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         left_ff  <= left_in;
         off_ff   <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      bufpos_ff <= bufpos_in;
      upos_ff   <= upos_in;
      srv_ff    <= srv_in;
      rbase_ff  <= rbase_in;
      width_ff  <= width_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      dcnt_ff   <= dcnt_in;
      nseg_ff   <= nseg_in;
   end

endmodule

FILE: rtl/stripe_segment_splitter_core.sv
// ----------------------------------------------------------------------------
// Stripe segment splitter core
// Cuts file I/O buffers into per-server segments over a round-robin stripe.
// ----------------------------------------------------------------------------
// Usage. Request words enter through a queue port (req_push, req_full); a
// word with new_request set opens a request at file_offset for
// request_length bytes, capped at the per-server request limit times the
// server count. Every word carries one buffer length, and the buffer comes
// out as segment words on the result queue (rsp_empty, rsp_pop), at most
// seventeen per buffer, the final one marked last unless the seventeen run
// out first. Buffers after the request is fully covered give no words. The
// csr port writes the unit size, the server count and the per-server limit;
// the user must write it only while the block is idle, which is not enforced.
// Throughput: a buffer is dequeued in the idle state, then the back end
// writes one segment word per cycle while the result queue has room. The
// first buffer of a request, the first after a register write and a buffer
// that wraps past the top of the offset space also run the stripe mapping:
// a setup step, the bit-serial divide by the stripe width and a subtract
// step per server passed to pick the server. A word that needs no mapping
// passes through the command queue and the back end's idle state.
// Reset empties both queues, restores the register defaults and clears the
// request. A stalled receiver fills the result queue; the back end then
// holds, the command queue fills behind it, and req_full rises.
// ----------------------------------------------------------------------------
module stripe_segment_splitter_core #(
   parameter int CMD_DEPTH = ssplt_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = ssplt_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  ssplt_pkg::req_type               req_data,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output ssplt_pkg::rsp_type               rsp_data,
   input  logic                             csr_we,
   input  logic [ssplt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssplt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ssplt_pkg::*;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_wdata, cmd_rdata;
   cfg_type cfg;
   logic    seg_push, seg_full;
   rsp_type seg_wdata;

   // Front end: register file and request classification.
   ssplt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_wdata),
      .cfg       (cfg)
   );

   assign req_full = cmd_full;

   // Command queue lets the front keep accepting while the back is mapping.
   ssplt_fifo #(
      .DEPTH (CMD_DEPTH),
      .WIDTH ($bits(cmd_type))
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   // Back end: stripe mapping and segment generation.
   ssplt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_full  (seg_full),
      .rsp_push  (seg_push),
      .rsp_wdata (seg_wdata)
   );

   // Result queue parts the back end from the receiver.
   ssplt_fifo #(
      .DEPTH (RSP_DEPTH),
      .WIDTH ($bits(rsp_type))
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (seg_push),
      .wdata (seg_wdata),
      .full  (seg_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

FILE: rtl/ssplt_checker.sv
// ----------------------------------------------------------------------------
// Stripe segment splitter port checker
// Watches the top level's queue ports for properties of the segment words.
// ----------------------------------------------------------------------------
`include "stripe_segment_splitter_core_macros.svh"

module ssplt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input ssplt_pkg::rsp_type rsp_data
);

   import ssplt_pkg::*;

   // Reset leaves both queues empty.
   `SSPLT_ASSERT_ALWAYS(a_reset_empty, reset |=> rsp_empty && !req_full, "queues not empty after reset")

   // A waiting word stays put until it is taken.
   `SSPLT_ASSERT(a_rsp_hold, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data), "result word changed while stalled")

   // Every segment carries at least one byte.
   `SSPLT_ASSERT(a_seg_nonzero, !rsp_empty |-> rsp_data.seg_count != '0, "empty segment")

   // Covering the request always ends the current buffer.
   `SSPLT_ASSERT(a_done_last, !rsp_empty && rsp_data.request_done |-> rsp_data.last, "request done without last")

endmodule

bind stripe_segment_splitter_core ssplt_checker u_checker (.*);

FILE: tb/ssplt_segment_checker.sv
// ----------------------------------------------------------------------------
// Stripe segment splitter checker
// Watches the request, result and register ports of the splitter, predicts
// the segment words each accepted request word should produce and compares
// every popped segment word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ssplt_segment_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_full,
   input  ssplt_pkg::req_type               req_data,
   input  logic                             rsp_empty,
   input  logic                             rsp_pop,
   input  ssplt_pkg::rsp_type               rsp_data,
   input  logic                             csr_we,
   input  logic [ssplt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssplt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               error_count,
   output int                               segments_pending
);
   import ssplt_pkg::*;

   localparam int MAX_PIECES = 17;  // most segments one buffer can yield
   localparam int SHOW_LIMIT = 10;

   // Register copies as written, clamped only where they are used.
   logic [UNIT_W-1:0]    unit_reg;
   logic [COUNT_W-1:0]   count_reg;
   logic [UNIT_W-1:0]    mrs_reg;

   // Request position: next file byte and bytes still to place.
   logic [OFF_W-1:0]     next_offset;
   logic [REQ_LEN_W-1:0] bytes_to_place;

   rsp_type segments_due[$];

   function automatic longint unsigned bounded(input longint unsigned v,
                                               input longint unsigned lo,
                                               input longint unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic string describe(input rsp_type s);
      return $sformatf("srv %0d off 0x%h cnt %0d bufoff %0d last %0b done %0b",
                       s.server_index, s.server_offset, s.seg_count,
                       s.buffer_offset, s.last, s.request_done);
   endfunction

   // Cuts one buffer at stripe-unit boundaries, at the buffer end and at the
   // end of the request, queueing one segment word per piece.
   task automatic cut_buffer(input req_type w);
      longint unsigned unit_b, servers, width_b, cap;
      longint unsigned left_in_buf, buf_pos, piece, pos;
      rsp_type seg;
      int n;
      unit_b  = bounded(unit_reg, UNIT_MIN, UNIT_MAX);
      servers = bounded(count_reg, 1, MAX_SERVERS);
      if (w.new_request) begin
         cap = bounded(mrs_reg, UNIT_MIN, UNIT_MAX) * servers;
         next_offset = w.file_offset;
         bytes_to_place = (w.request_length < cap) ? w.request_length
                                                   : REQ_LEN_W'(cap);
      end
      width_b = unit_b * servers;
      left_in_buf = w.buffer_length;
      buf_pos = 0;
      n = 0;
      while (left_in_buf != 0 && bytes_to_place != 0 && n < MAX_PIECES) begin
         pos = next_offset % unit_b;
         piece = unit_b - pos;
         if (piece > bytes_to_place) begin
            piece = bytes_to_place;
         end
         if (piece > left_in_buf) begin
            piece = left_in_buf;
         end
         seg.server_index  = SRV_OUT_W'((next_offset / unit_b) % servers);
         seg.server_offset = OFF_W'((next_offset / width_b) * unit_b + pos);
         seg.seg_count     = BUF_W'(piece);
         seg.buffer_offset = BUF_W'(buf_pos);
         bytes_to_place = bytes_to_place - REQ_LEN_W'(piece);
         left_in_buf = left_in_buf - piece;
         buf_pos = buf_pos + piece;
         // The file offset wraps at the top of the 48-bit space.
         next_offset = next_offset + OFF_W'(piece);
         seg.last = (left_in_buf == 0 || bytes_to_place == 0);
         seg.request_done = (bytes_to_place == 0);
         segments_due.push_back(seg);
         n++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         unit_reg = UNIT_RESET;
         count_reg = COUNT_RESET;
         mrs_reg = MRS_RESET;
         next_offset = '0;
         bytes_to_place = '0;
         error_count = 0;
         segments_due.delete();
      end else begin
         // Results first: a word pushed at this edge cannot already be out.
         if (rsp_pop && !rsp_empty) begin
            if (segments_due.size() == 0) begin
               error_count++;
               if (error_count <= SHOW_LIMIT) begin
                  $display("%0t: unexpected segment word: %s", $time,
                           describe(rsp_data));
               end
            end else begin
               want = segments_due.pop_front();
               if (want.server_index  !== rsp_data.server_index  ||
                   want.server_offset !== rsp_data.server_offset ||
                   want.seg_count     !== rsp_data.seg_count     ||
                   want.buffer_offset !== rsp_data.buffer_offset ||
                   want.last          !== rsp_data.last          ||
                   want.request_done  !== rsp_data.request_done) begin
                  error_count++;
                  if (error_count <= SHOW_LIMIT) begin
                     $display("%0t: segment mismatch", $time);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(rsp_data));
                  end
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_UNIT_SIZE:        unit_reg = csr_wdata[UNIT_W-1:0];
               CSR_SERVER_COUNT:     count_reg = csr_wdata[COUNT_W-1:0];
               CSR_MAX_REQUEST_SIZE: mrs_reg = csr_wdata[UNIT_W-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            cut_buffer(req_data);
         end
      end
      segments_pending = segments_due.size();
   end

endmodule

FILE: tb/stripe_segment_splitter_core_test.sv
// ----------------------------------------------------------------------------
// Stripe segment splitter testbench
// Drives request words and register settings into the splitter, pops its
// segment words under a random stall pattern and lets the checker compare
// them against its own prediction. Directed corner words come first, then
// random request sequences over a series of stripe settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stripe_segment_splitter_core_test;
   import ssplt_pkg::*;

   // The one register index the block does not decode; writes to it must
   // leave the stripe geometry alone.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int NUM_SETTINGS   = 8;
   localparam int RANDOM_ITEMS   = 470;
   // Covers a full command queue of words that each rerun the stripe
   // mapping, with margin.
   localparam int SETTLE_CYCLES  = 400;
   // Cycles without any accepted word before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 4000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   req_type               req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int segments_pending;

   int burst_left = 0;
   int pop_hold = 0;
   int idle_cycles = 0;
   int words_sent = 0;
   int requests_opened = 0;
   int segments_seen = 0;
   int settings_run = 0;
   bit request_open = 1'b0;
   int buffers_in_request = 0;
   int buffers_planned = 0;

   stripe_segment_splitter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ssplt_segment_checker segment_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .segments_pending (segments_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver alternates between pop runs and stalls. Most runs are
   // short so stalls land on every phase of a buffer's segments; now and
   // then a long run lets the block stream with no back pressure at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
      end else if (rsp_pop) begin
         rsp_pop <= 1'b0;
         pop_hold <= $urandom_range(0, 9);
      end else begin
         rsp_pop <= 1'b1;
         pop_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                                 : $urandom_range(0, 20);
      end
   end

   // Watchdog: any accepted word on either side restarts the count. It
   // also tallies the segment words taken for the closing summary.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         segments_seen <= segments_seen + 1;
      end
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles", idle_cycles);
         $display("stripe_segment_splitter_core_test: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request word and returns at the edge that accepts it. The
   // sender runs in bursts; at the end of a burst it may drop req_push for
   // a random gap. Within a burst req_push simply stays high.
   task automatic push_word(input bit opens, input logic [OFF_W-1:0] off,
                            input logic [REQ_LEN_W-1:0] len,
                            input logic [BUF_W-1:0] blen);
      int gap;
      req_type w;
      w.new_request = opens;
      w.file_offset = off;
      w.request_length = len;
      w.buffer_length = blen;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      words_sent++;
      if (opens) begin
         requests_opened++;
      end
   endtask

   // Holds the sender until every predicted segment word has been popped,
   // then optionally lets the block finish words that produce nothing.
   task automatic quiesce(input int hold);
      req_push <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (segments_pending != 0);
      @(posedge clock);
      repeat (hold) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Programs one stripe geometry. The undecoded index gets random data
   // first, so a decode slip would show up as a wrong geometry.
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] unit_v,
                                input logic [CSR_DATA_W-1:0] count_v,
                                input logic [CSR_DATA_W-1:0] mrs_v);
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      write_reg(CSR_UNIT_SIZE, unit_v);
      write_reg(CSR_SERVER_COUNT, count_v);
      write_reg(CSR_MAX_REQUEST_SIZE, mrs_v);
      csr_we <= 1'b0;
      settings_run++;
   endtask

   // Random traffic: mostly well-formed requests (an opening word followed
   // by a planned number of buffers), with requests cut short by a new one,
   // empty buffers, empty requests and buffers past the end of a request.
   task automatic send_random(input int count);
      int pick;
      bit opens;
      logic [OFF_W-1:0] off;
      logic [REQ_LEN_W-1:0] len;
      logic [BUF_W-1:0] blen;
      for (int i = 0; i < count; i++) begin
         off = OFF_W'({$urandom, $urandom});
         len = $urandom;
         blen = BUF_W'($urandom);
         opens = !request_open || buffers_in_request >= buffers_planned ||
                 $urandom_range(0, 19) == 0;
         if (opens) begin
            request_open = 1'b1;
            buffers_in_request = 0;
            buffers_planned = $urandom_range(1, 10);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               // Just below the top of the offset space, so the request may wrap.
               off = {OFF_W{1'b1}} - OFF_W'($urandom_range(0, 200000));
            end else if (pick < 40) begin
               off = OFF_W'($urandom_range(0, 1 << 20));
            end else if (pick < 60) begin
               // On or one byte before a 4 KiB boundary.
               off = (off & ~OFF_W'(12'hFFF)) - OFF_W'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               len = '0;
            end else if (pick < 40) begin
               len = $urandom_range(1, 20000);
            end else if (pick < 70) begin
               len = $urandom_range(1, 300000);
            end else if (pick < 80) begin
               len = '1;
            end
         end
         buffers_in_request++;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            blen = '0;
         end else if (pick < 25) begin
            blen = BUF_W'($urandom_range(1, 64));
         end else if (pick < 55) begin
            blen = BUF_W'($urandom_range(1, 8192));
         end else if (pick < 65) begin
            blen = '1;
         end
         push_word(opens, off, len, blen);
         // Occasionally let the result side run completely dry mid-phase.
         if ($urandom_range(0, 149) == 0) begin
            quiesce(0);
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] unit_v, count_v, mrs_v;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Smallest unit over the widest stripe, so buffers split into many
      // segments and the unaligned full buffer yields the most of them.
      apply_setting(4096, 16, 65536);

      // Empty request, then a buffer once the request is already done.
      push_word(1'b1, '0, '0, 100);
      push_word(1'b0, '0, '0, 500);
      // Longest request length (capped), empty buffer, then a full buffer and a one-byte buffer.
      push_word(1'b1, '0, '1, '0);
      push_word(1'b0, '1, '1, '1);
      push_word(1'b0, '0, '0, 1);
      // One byte short of a unit boundary: the full buffer crosses 17 units.
      push_word(1'b1, 48'd4095, '1, '1);
      // Top of the offset space with a buffer longer than what is left.
      push_word(1'b1, '1, 10000, '1);
      push_word(1'b0, '0, '0, 7);
      // A request that wraps past the top of the offset space mid-buffer.
      push_word(1'b1, {OFF_W{1'b1}} - OFF_W'(4999), 20000, 3000);
      push_word(1'b0, '0, '0, 3000);
      push_word(1'b0, '0, '0, '1);
      // Shortest request.
      push_word(1'b1, 48'h1234_5678_9ABC, 1, 1);
      // A request abandoned by a new one before it is done.
      push_word(1'b1, 48'd12345, 5000, 2000);
      push_word(1'b1, 48'd100000, 70000, '1);
      push_word(1'b0, '0, '0, '1);
      push_word(1'b0, '0, '0, 16'h8000);

      // Each phase drains, waits out silent work, then programs a new
      // geometry. The first five cover both ends of every range and the
      // clamping of values outside them; the rest are random. A request may
      // stay open across a phase boundary and continue under the new one.
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         quiesce(SETTLE_CYCLES);
         case (p)
            0: begin unit_v = 1048576; count_v = 1;  mrs_v = 1048576; end
            1: begin unit_v = 4096;    count_v = 16; mrs_v = 4096;    end
            2: begin unit_v = 0;       count_v = 0;  mrs_v = 0;       end
            3: begin unit_v = '1;      count_v = '1; mrs_v = '1;      end
            4: begin unit_v = 4095;    count_v = 17; mrs_v = 1048577; end
            default: begin
               unit_v = ($urandom_range(0, 1) == 0) ?
                        CSR_DATA_W'(4096 << $urandom_range(0, 8)) :
                        CSR_DATA_W'($urandom_range(4096, 1048576));
               count_v = CSR_DATA_W'($urandom_range(1, 16));
               mrs_v = CSR_DATA_W'($urandom_range(4096, 1048576));
            end
         endcase
         apply_setting(unit_v, count_v, mrs_v);
         send_random(RANDOM_ITEMS / NUM_SETTINGS);
      end

      // Drain, then give any stray word time to show up.
      quiesce(SETTLE_CYCLES);

      $display("Run covered %0d request words (%0d opening a request) and %0d segment words",
               words_sent, requests_opened, segments_seen);
      $display("over %0d stripe settings, including clamped register values.",
               settings_run);
      if (error_count == 0 && segments_pending == 0) begin
         $display("stripe_segment_splitter_core_test: PASS");
      end else begin
         $display("%0d failed checks, %0d segment words never arrived",
                  error_count, segments_pending);
         $display("stripe_segment_splitter_core_test: FAIL");
      end
      $finish;
   end

endmodule
